### design/mbs_pkg.sv
// Shared types, widths and constants of the melody beeper sequencer.
// No dependencies; every other design file imports this package.
package mbs_pkg;

    localparam int CHUNKS_PER_NOTE = 4;
    localparam int NOTE_COUNT      = 2;
    localparam int CHUNK_W         = $clog2(CHUNKS_PER_NOTE);
    localparam int CYCLE_LEN       = 2 * NOTE_COUNT * CHUNKS_PER_NOTE;
    localparam int CYCLE_W         = $clog2(CYCLE_LEN);
    localparam int SETTLE_LIMIT    = 4 * NOTE_COUNT * CHUNKS_PER_NOTE + 4;

    localparam int TEMPO_W = 16;
    localparam int PAUSE_W = 16;
    localparam int REP_W   = 8;
    localparam int PER_W   = 12;
    localparam int BEATS_W = 8;
    localparam int HALF_W  = PER_W - 1;
    localparam int QUIET_W = PAUSE_W - CHUNK_W;
    localparam int PROD_W  = BEATS_W + TEMPO_W;
    localparam int LEN_W   = PROD_W - CHUNK_W;
    localparam int SUM_W   = LEN_W + 1;
    localparam int TC_W    = REP_W + LEN_W;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS_PER_NOTE - 1);
    localparam logic [CYCLE_W-1:0] SKIP_ONE   = CYCLE_W'(SETTLE_LIMIT % CYCLE_LEN);
    localparam logic [CYCLE_W-1:0] SKIP_TWO   = CYCLE_W'((SETTLE_LIMIT - 1) % CYCLE_LEN);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] IDX_TEMPO         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] IDX_PAUSE         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] IDX_REST_REPEAT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] IDX_FIRST_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] IDX_FIRST_BEATS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] IDX_SECOND_PERIOD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] IDX_SECOND_BEATS  = 3'd6;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo_ticks;
        logic [PAUSE_W-1:0] pause_ticks;
        logic [REP_W-1:0]   rest_repeat;
        logic [PER_W-1:0]   first_period;
        logic [BEATS_W-1:0] first_beats;
        logic [PER_W-1:0]   second_period;
        logic [BEATS_W-1:0] second_beats;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        tempo_ticks:   16'd50000,
        pause_ticks:   16'd10000,
        rest_repeat:   8'd100,
        first_period:  12'd477,
        first_beats:   8'd16,
        second_period: 12'd0,
        second_beats:  8'd16
    };

    typedef struct packed {
        logic [LEN_W-1:0]   len0;
        logic [LEN_W-1:0]   len1;
        logic               empty0;
        logic               empty1;
        logic [QUIET_W-1:0] quiet;
    } note_info_t;

    typedef struct packed {
        logic stop;
        logic click;
        logic start_req;
    } item_t;

    typedef struct packed {
        logic note_index;
        logic playing;
        logic beeper;
    } result_t;

    localparam int ITEM_W      = $bits(item_t);
    localparam int RESULT_W    = $bits(result_t);
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_HIGH  = 5'b00010,
        PH_LOW   = 5'b00100,
        PH_REST  = 5'b01000,
        PH_PAUSE = 5'b10000
    } phase_t;

    function automatic logic note_empty(input logic [LEN_W-1:0] len,
                                        input logic [PER_W-1:0] period,
                                        input logic [REP_W-1:0] rep);
        return (len == '0) || (period == PER_W'(1)) || ((period == '0) && (rep == '0));
    endfunction

endpackage

### design/melody_beeper_sequencer.sv
// Top level of the melody beeper sequencer: stream channels, input and result registers.
// Depends on mbs_pkg, mbs_cfg, mbs_note_info and mbs_engine.
//
// Use: send one item per microsecond tick on the s_ channel (start_req, click, stop).
// Each item yields exactly one result on the m_ channel: the beeper pin level for
// that tick, whether the melody is playing, and the index of the current note.
// A start request from idle begins the two-note loop; click or stop ends it at
// the next chunk end or, when the pause is nonzero, at the end of a pause chunk.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write them only while no item is in flight, the block does not enforce it.
// An accepted item is held in the input register, worked on by the engine and
// its result is held in the result register. Throughput: one item per cycle
// while results are taken; the two registers decouple the sides, so an item is
// taken while a result waits. Stall: when m_tready stays low the result holds,
// the input register fills and then s_tready drops until the result is taken.
// Reset: synchronous on aresetn low; the player goes idle, both channels empty,
// and the registers take their power-on values.
module melody_beeper_sequencer
    import mbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] start_req, [1] click, [2] stop
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] beeper, [1] playing, [2] note_index
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t       cfg;
    note_info_t info;
    result_t    result;

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg, in_item_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg, out_result_next;
    logic [RESULT_W-1:0] out_bits;
    logic       step;

    mbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbs_note_info u_note_info (
        .cfg  (cfg),
        .info (info)
    );

    mbs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .info    (info),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_item_next    = in_item_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_item_next  = s_tdata[ITEM_W-1:0];
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        if (step) begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    assign out_bits = out_result_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_bits);

endmodule

### design/mbs_cfg.sv
// Configuration register file of the melody beeper sequencer.
// Depends on mbs_pkg for the register indexes, widths and reset values.
module mbs_cfg
    import mbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                IDX_TEMPO:         cfg_next.tempo_ticks   = cfg_wdata[TEMPO_W-1:0];
                IDX_PAUSE:         cfg_next.pause_ticks   = cfg_wdata[PAUSE_W-1:0];
                IDX_REST_REPEAT:   cfg_next.rest_repeat   = cfg_wdata[REP_W-1:0];
                IDX_FIRST_PERIOD:  cfg_next.first_period  = cfg_wdata[PER_W-1:0];
                IDX_FIRST_BEATS:   cfg_next.first_beats   = cfg_wdata[BEATS_W-1:0];
                IDX_SECOND_PERIOD: cfg_next.second_period = cfg_wdata[PER_W-1:0];
                IDX_SECOND_BEATS:  cfg_next.second_beats  = cfg_wdata[BEATS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/mbs_note_info.sv
// Per-note chunk lengths, empty-chunk flags and pause chunk length.
// Depends on mbs_pkg; fed from the configuration registers.
module mbs_note_info
    import mbs_pkg::*;
(
    input  cfg_t       cfg,
    output note_info_t info
);

    logic [PROD_W-1:0] prod0;
    logic [PROD_W-1:0] prod1;

    assign prod0 = cfg.first_beats * cfg.tempo_ticks;
    assign prod1 = cfg.second_beats * cfg.tempo_ticks;

    assign info.len0   = prod0[PROD_W-1:CHUNK_W];
    assign info.len1   = prod1[PROD_W-1:CHUNK_W];
    assign info.empty0 = note_empty(prod0[PROD_W-1:CHUNK_W], cfg.first_period,
                                    cfg.rest_repeat);
    assign info.empty1 = note_empty(prod1[PROD_W-1:CHUNK_W], cfg.second_period,
                                    cfg.rest_repeat);
    assign info.quiet  = cfg.pause_ticks[PAUSE_W-1:CHUNK_W];

endmodule

### design/mbs_engine.sv
// Sequencer state and per-tick update: segment boundaries, chunk walk, tick count.
// Depends on mbs_pkg; takes configuration and note info from mbs_cfg and mbs_note_info.
module mbs_engine
    import mbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  note_info_t info,
    input  logic       step,
    input  item_t      item,
    output result_t    result
);

    phase_t             phase_reg, phase_next;
    logic               note_reg, note_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [TC_W-1:0]    tc_reg, tc_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               stop_reg, stop_next;
    logic               pend_reg, pend_next;
    logic [REP_W-1:0]   rep_reg, rep_next;

    logic [TC_W-1:0]    rest_prod;
    logic [TC_W-1:0]    cur_tc;
    logic               start_now;

    phase_t             pre_phase;
    logic               pre_note;
    logic [CHUNK_W-1:0] pre_chunk;
    logic [LEN_W-1:0]   pre_len;
    logic [SUM_W-1:0]   pre_sum;
    logic               pre_stop;
    logic [TC_W-1:0]    pre_tc;
    logic               pre_rest;
    logic               need_settle;

    logic [PER_W-1:0]   per_n, per_m;
    logic [HALF_W-1:0]  half_n;
    logic [LEN_W-1:0]   len_n, len_m;
    logic               empty_n, empty_m, empty_cur;
    logic               stop_now;
    logic [SUM_W-1:0]   sum_add;

    phase_t             post_phase;
    logic               post_note;
    logic [CHUNK_W-1:0] post_chunk;
    logic [LEN_W-1:0]   post_len;
    logic [SUM_W-1:0]   post_sum;
    logic               post_stop;
    logic [TC_W-1:0]    post_tc;
    logic               post_rest;

    logic               chunk_end;
    logic               from_pause;
    logic               two_steps;
    logic               land_en;
    logic [PER_W-1:0]   land_per;
    logic [CYCLE_W-1:0] wrap_pos;
    logic               beep;

    assign rest_prod = rep_reg * len_reg;
    assign cur_tc    = pend_reg ? rest_prod - TC_W'(1) : tc_reg;
    assign start_now = (phase_reg == PH_IDLE) && item.start_req;

    always_comb begin
        if (start_now) begin
            pre_note  = 1'b0;
            pre_chunk = '0;
            pre_len   = info.len0;
            pre_sum   = '0;
            pre_stop  = item.stop;
            if (info.empty0) begin
                pre_phase = PH_REST;
                pre_tc    = '0;
                pre_rest  = 1'b0;
            end else if (cfg.first_period == '0) begin
                pre_phase = PH_REST;
                pre_tc    = '0;
                pre_rest  = 1'b1;
            end else begin
                pre_phase = PH_HIGH;
                pre_tc    = TC_W'(cfg.first_period[PER_W-1:1]);
                pre_rest  = 1'b0;
            end
        end else begin
            pre_phase = phase_reg;
            pre_note  = note_reg;
            pre_chunk = chunk_reg;
            pre_len   = len_reg;
            pre_sum   = sum_reg;
            pre_stop  = stop_reg | item.stop;
            pre_tc    = cur_tc;
            pre_rest  = 1'b0;
        end
    end

    assign need_settle = (pre_phase != PH_IDLE) && !pre_rest && (pre_tc == '0);

    assign per_n     = pre_note ? cfg.second_period : cfg.first_period;
    assign per_m     = pre_note ? cfg.first_period : cfg.second_period;
    assign half_n    = per_n[PER_W-1:1];
    assign len_n     = pre_note ? info.len1 : info.len0;
    assign len_m     = pre_note ? info.len0 : info.len1;
    assign empty_n   = pre_note ? info.empty1 : info.empty0;
    assign empty_m   = pre_note ? info.empty0 : info.empty1;
    assign empty_cur = note_empty(pre_len, per_n, cfg.rest_repeat);
    assign stop_now  = pre_stop | item.click;
    assign sum_add   = pre_sum + SUM_W'(per_n);

    always_comb begin
        post_phase = pre_phase;
        post_note  = pre_note;
        post_chunk = pre_chunk;
        post_len   = pre_len;
        post_sum   = pre_sum;
        post_stop  = pre_stop;
        post_tc    = pre_tc;
        post_rest  = pre_rest;
        chunk_end  = 1'b0;
        from_pause = 1'b0;
        two_steps  = 1'b0;
        land_en    = 1'b0;
        land_per   = per_n;
        wrap_pos   = '0;

        if (need_settle) begin
            unique case (pre_phase)
                PH_HIGH: begin
                    if (half_n != '0) begin
                        post_phase = PH_LOW;
                        post_tc    = TC_W'(half_n);
                    end else begin
                        chunk_end = 1'b1;
                        two_steps = 1'b1;
                    end
                end
                PH_LOW: begin
                    if ((half_n == '0) || (sum_add >= SUM_W'(pre_len))) begin
                        chunk_end = 1'b1;
                    end else begin
                        post_phase = PH_HIGH;
                        post_tc    = TC_W'(half_n);
                        post_sum   = sum_add;
                    end
                end
                PH_REST: begin
                    chunk_end = 1'b1;
                end
                PH_PAUSE: begin
                    chunk_end  = 1'b1;
                    from_pause = 1'b1;
                end
                default: ;
            endcase
        end

        if (chunk_end) begin
            post_stop = stop_now;
            if (stop_now) begin
                if (!from_pause && (info.quiet != '0)) begin
                    post_phase = PH_PAUSE;
                    post_chunk = '0;
                    post_tc    = TC_W'(info.quiet);
                end else begin
                    post_phase = PH_IDLE;
                    post_note  = 1'b0;
                    post_chunk = '0;
                    post_len   = '0;
                    post_sum   = '0;
                    post_tc    = '0;
                    post_stop  = 1'b0;
                end
            end else begin
                priority if (!from_pause && (pre_chunk != LAST_CHUNK) && !empty_cur) begin
                    land_en    = 1'b1;
                    post_chunk = pre_chunk + CHUNK_W'(1);
                end else if (from_pause && (pre_chunk != LAST_CHUNK) && (info.quiet != '0)) begin
                    post_phase = PH_PAUSE;
                    post_chunk = pre_chunk + CHUNK_W'(1);
                    post_tc    = TC_W'(info.quiet);
                end else if (!from_pause && (info.quiet != '0)) begin
                    post_phase = PH_PAUSE;
                    post_chunk = '0;
                    post_tc    = TC_W'(info.quiet);
                end else if (!empty_m) begin
                    land_en    = 1'b1;
                    land_per   = per_m;
                    post_note  = ~pre_note;
                    post_chunk = '0;
                    post_len   = len_m;
                end else if (from_pause && (info.quiet != '0)) begin
                    post_phase = PH_PAUSE;
                    post_note  = ~pre_note;
                    post_chunk = '0;
                    post_len   = len_m;
                    post_tc    = TC_W'(info.quiet);
                end else if (!empty_n) begin
                    land_en    = 1'b1;
                    post_chunk = '0;
                    post_len   = len_n;
                end else begin
                    // every chunk is empty: stop where the boundary budget runs out
                    wrap_pos   = {1'b0, from_pause, pre_chunk}
                               + (two_steps ? SKIP_TWO : SKIP_ONE);
                    post_note  = wrap_pos[CHUNK_W+1] ? ~pre_note : pre_note;
                    post_len   = wrap_pos[CHUNK_W+1] ? len_m : len_n;
                    post_chunk = wrap_pos[CHUNK_W-1:0];
                    post_phase = wrap_pos[CHUNK_W] ? PH_PAUSE : PH_REST;
                    post_sum   = '0;
                    post_tc    = '0;
                end
            end
        end

        if (land_en) begin
            post_sum = '0;
            if (land_per == '0) begin
                post_phase = PH_REST;
                post_rest  = 1'b1;
                post_tc    = '0;
            end else begin
                post_phase = PH_HIGH;
                post_tc    = TC_W'(land_per[PER_W-1:1]);
            end
        end
    end

    always_comb begin
        phase_next = post_phase;
        note_next  = post_note;
        chunk_next = post_chunk;
        len_next   = post_len;
        sum_next   = post_sum;
        stop_next  = post_stop && (post_phase != PH_IDLE);
        if (post_rest) begin
            tc_next   = '0;
            pend_next = 1'b1;
            rep_next  = cfg.rest_repeat;
            beep      = 1'b0;
        end else begin
            tc_next   = (post_tc != '0) ? post_tc - TC_W'(1) : post_tc;
            pend_next = 1'b0;
            rep_next  = rep_reg;
            beep      = (post_phase == PH_HIGH) && (post_tc != '0);
        end
    end

    assign result.beeper     = beep;
    assign result.playing    = (post_phase != PH_IDLE);
    assign result.note_index = post_note;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            note_reg  <= 1'b0;
            chunk_reg <= '0;
            tc_reg    <= '0;
            sum_reg   <= '0;
            len_reg   <= '0;
            stop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            note_reg  <= note_next;
            chunk_reg <= chunk_next;
            tc_reg    <= tc_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            stop_reg  <= stop_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            rep_reg <= rep_next;
        end
    end

endmodule
